@@ rtl/btg_pkg.sv @@
// ----------------------------------------------------------------------------
// btg_pkg - shared types and constants for the buzzer tone generator
// Command and result beat layouts, sequencer states, timing constants.
// ----------------------------------------------------------------------------
package btg_pkg;

	localparam int FREQ_W   = 16;
	localparam int DUR_W    = 16;
	localparam int HALF_W   = 19;   // half period in ticks, at most 500000
	localparam int COUNT_W  = 26;   // tick and period counts, at most 65535000
	localparam int DIVR_W   = HALF_W + 1;
	localparam int STEP_W   = 5;

	localparam logic [HALF_W-1:0]  HALF_US_NUM = HALF_W'(500000);
	localparam logic [9:0]         US_PER_MS   = 10'd1000;
	localparam logic [STEP_W-1:0]  DIV1_STEPS  = STEP_W'(HALF_W);
	localparam logic [STEP_W-1:0]  DIV2_STEPS  = STEP_W'(COUNT_W);

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_TICK  = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [FREQ_W-1:0] freq_hz;
		logic [DUR_W-1:0]  length_ms;
	} cmd_t;

	typedef struct packed {
		logic pin_level;
		logic sounding;
		logic busy_res;
		logic done_res;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV1,
		ST_DIV2,
		ST_OUT
	} state_t;

endpackage

@@ rtl/buzzer_tone_generator.sv @@
// ----------------------------------------------------------------------------
// buzzer_tone_generator - square wave tone generator for a buzzer pin
// Start commands set up a tone or rest; tick beats advance it by one microsecond.
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// cmd      in   cmd_valid/cmd_stall  btg_pkg::cmd_t (mode, freq_hz, length_ms)
// res      out  res_valid/res_stall  btg_pkg::res_t (pin, sounding, busy, done)
// cfg      in   cfg_valid/cfg_ready  cfg_data = active_low
//
// A tick beat or a rest start goes from ST_IDLE straight to ST_OUT.
// A tone start passes ST_DIV1 and ST_DIV2: one shared restoring divider stage runs
// 19 steps for 500000/freq, then 26 steps for total/(2*half period).
// One command at a time: cmd_stall is high from acceptance until the result
// beat has left. arst_n clears all control state; active_low resets to 1.
// A held result beat stays stable while res_stall is high.
module buzzer_tone_generator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  btg_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output btg_pkg::res_t res,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_data
);
	import btg_pkg::*;

	state_t state_q, state_nx;

	logic               active_low_q;
	logic [HALF_W-1:0]  hp_q;
	logic [COUNT_W-1:0] per_q;
	logic [HALF_W-1:0]  ph_q;
	logic               off_q;
	logic [COUNT_W-1:0] rt_q;
	logic               run_q;
	logic               rest_q;
	logic [COUNT_W-1:0] total_q;
	res_t               res_q;

	// shared divider
	logic [COUNT_W-1:0] quo_q;
	logic [DIVR_W-1:0]  rem_q;
	logic [DIVR_W-1:0]  dvs_q;
	logic [STEP_W-1:0]  cnt_q;
	logic [DIVR_W:0]    rem_sh;
	logic [DIVR_W+1:0]  diff;
	logic               q_bit;
	logic [COUNT_W-1:0] quo_nx;
	logic [DIVR_W-1:0]  rem_nx;

	logic               cmd_acc;
	logic [COUNT_W-1:0] total_nx;

	// tick update
	logic               tk_run, tk_rest, tk_off, tk_done;
	logic [HALF_W-1:0]  tk_ph, ph_dec;
	logic [COUNT_W-1:0] tk_per, tk_rt, per_dec, rt_dec;

	function automatic res_t make_res(logic snd, logic busy, logic done, logic al);
		res_t r;
		r.pin_level = snd ^ al;
		r.sounding  = snd;
		r.busy_res  = busy;
		r.done_res  = done;
		return r;
	endfunction

	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign cfg_ready = 1'b1;
	assign total_nx  = COUNT_W'(cmd.length_ms * US_PER_MS);

	always_comb begin
		rem_sh = {rem_q, quo_q[COUNT_W-1]};
		diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
		q_bit  = !diff[DIVR_W+1];
		rem_nx = q_bit ? diff[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
		quo_nx = {quo_q[COUNT_W-2:0], q_bit};
	end

	always_comb begin
		rt_dec  = rt_q - 1'b1;
		ph_dec  = ph_q - 1'b1;
		per_dec = per_q - 1'b1;
		tk_run  = run_q;
		tk_rest = rest_q;
		tk_off  = off_q;
		tk_ph   = ph_q;
		tk_per  = per_q;
		tk_rt   = rt_q;
		tk_done = 1'b0;
		if (run_q) begin
			if (rest_q) begin
				tk_rt = rt_dec;
				if (rt_dec == '0) begin
					tk_run  = 1'b0;
					tk_rest = 1'b0;
					tk_done = 1'b1;
				end
			end else begin
				tk_ph = ph_dec;
				if (ph_dec == '0) begin
					if (!off_q) begin
						tk_off = 1'b1;
						tk_ph  = hp_q;
					end else begin
						tk_per = per_dec;
						if (per_dec == '0) begin
							tk_run  = 1'b0;
							tk_off  = 1'b0;
							tk_done = 1'b1;
						end else begin
							tk_off = 1'b0;
							tk_ph  = hp_q;
						end
					end
				end
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_acc) begin
					if (cmd.mode == MODE_TICK || cmd.freq_hz == '0)
						state_nx = ST_OUT;
					else
						state_nx = ST_DIV1;
				end
			end
			ST_DIV1: if (cnt_q == STEP_W'(1)) state_nx = ST_DIV2;
			ST_DIV2: if (cnt_q == STEP_W'(1)) state_nx = ST_OUT;
			ST_OUT:  if (!res_stall) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_stall = (state_q != ST_IDLE);
		res_valid = (state_q == ST_OUT);
		res       = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			active_low_q <= 1'b1;
			hp_q         <= '0;
			per_q        <= '0;
			ph_q         <= '0;
			off_q        <= 1'b0;
			rt_q         <= '0;
			run_q        <= 1'b0;
			rest_q       <= 1'b0;
			cnt_q        <= '0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid && cfg_ready)
				active_low_q <= cfg_data;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_acc && cmd.mode == MODE_TICK) begin
						run_q  <= tk_run;
						rest_q <= tk_rest;
						off_q  <= tk_off;
						ph_q   <= tk_ph;
						per_q  <= tk_per;
						rt_q   <= tk_rt;
					end else if (cmd_acc) begin
						// start drops whatever was running
						run_q  <= 1'b0;
						rest_q <= 1'b0;
						off_q  <= 1'b0;
						ph_q   <= '0;
						per_q  <= '0;
						rt_q   <= '0;
						cnt_q  <= DIV1_STEPS;
						if (cmd.freq_hz == '0 && total_nx != '0) begin
							run_q  <= 1'b1;
							rest_q <= 1'b1;
							rt_q   <= total_nx;
						end
					end
				end
				ST_DIV1: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == STEP_W'(1)) begin
						hp_q  <= quo_nx[HALF_W-1:0];
						cnt_q <= DIV2_STEPS;
					end
				end
				ST_DIV2: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == STEP_W'(1) && quo_nx != '0) begin
						run_q <= 1'b1;
						per_q <= quo_nx;
						ph_q  <= hp_q;
						off_q <= 1'b0;
					end
				end
				ST_OUT: ;
				default: ;
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_acc && cmd.mode == MODE_TICK) begin
					res_q <= make_res(tk_run && !tk_rest && !tk_off, tk_run, tk_done,
						active_low_q);
				end else if (cmd_acc) begin
					total_q <= total_nx;
					quo_q   <= {HALF_US_NUM, {(COUNT_W-HALF_W){1'b0}}};
					rem_q   <= '0;
					dvs_q   <= DIVR_W'(cmd.freq_hz);
					res_q   <= make_res(1'b0, total_nx != '0, total_nx == '0,
						active_low_q);
				end
			end
			ST_DIV1: begin
				quo_q <= quo_nx;
				rem_q <= rem_nx;
				if (cnt_q == STEP_W'(1)) begin
					quo_q <= total_q;
					rem_q <= '0;
					dvs_q <= {quo_nx[HALF_W-1:0], 1'b0};
				end
			end
			ST_DIV2: begin
				quo_q <= quo_nx;
				rem_q <= rem_nx;
				if (cnt_q == STEP_W'(1))
					res_q <= make_res(quo_nx != '0, quo_nx != '0, quo_nx == '0,
						active_low_q);
			end
			ST_OUT: ;
			default: ;
		endcase
	end

	a_tone_counts: assert property (@(posedge clk) disable iff (!arst_n)
		run_q && !rest_q |-> hp_q != '0 && ph_q != '0 && per_q != '0)
		else $error("tone running with a zero count");

	a_rest_count: assert property (@(posedge clk) disable iff (!arst_n)
		run_q && rest_q |-> rt_q != '0 && !off_q)
		else $error("rest running with zero ticks left");

	a_div_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV1 || state_q == ST_DIV2) |-> cnt_q != '0)
		else $error("divider step count ran out");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.done_res |-> !res.busy_res && !res.sounding)
		else $error("done beat reports busy");

	a_busy_match: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.busy_res == run_q)
		else $error("result busy flag disagrees with state");

endmodule

@@ tb/buzzer_tone_generator_test.sv @@
// ----------------------------------------------------------------------------
// buzzer_tone_generator_test - self-checking bench for the buzzer tone generator
// Drives start and tick beats with random gaps and result stalls, predicts
// untyped result beats from a cycle-free model of the tone and rest counters,
// and checks each beat field by field. Polarity is switched between phases.
// ----------------------------------------------------------------------------
module buzzer_tone_generator_test;
	import btg_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int TONE_NUM    = 500000;   // half period in ticks is TONE_NUM / freq
	localparam int MS_TICKS    = 1000;
	localparam int RANDOM_LIVE = 150;      // live beats per random phase

	typedef struct packed {
		cmd_t beat;
		logic typed;    // 1: want holds the expected result as written
		res_t want;
	} stim_row_t;

	// pin, sounding, busy, done
	localparam res_t IDLE_HI = '{1'b1, 1'b0, 1'b0, 1'b0};
	localparam res_t DONE_HI = '{1'b1, 1'b0, 1'b0, 1'b1};
	localparam res_t TONE_ON = '{1'b0, 1'b1, 1'b1, 1'b0};
	localparam res_t REST_HI = '{1'b1, 1'b0, 1'b1, 1'b0};
	localparam res_t FROM_PREDICTOR = '0;

	localparam stim_row_t DIRECTED [18] = '{
		'{'{MODE_TICK,  16'h0000, 16'h0000}, 1'b1, IDLE_HI},   // tick while idle
		'{'{MODE_START, 16'h0000, 16'h0000}, 1'b1, DONE_HI},   // empty rest
		'{'{MODE_START, 16'hFFFF, 16'h0000}, 1'b1, DONE_HI},   // tone of no periods
		'{'{MODE_START, 16'd1,    16'd999},  1'b1, DONE_HI},   // longest half, too short
		'{'{MODE_START, 16'd1,    16'd1000}, 1'b1, TONE_ON},   // exactly one period
		'{'{MODE_TICK,  16'hFFFF, 16'h0000}, 1'b0, FROM_PREDICTOR},
		'{'{MODE_START, 16'hFFFF, 16'hFFFF}, 1'b1, TONE_ON},   // restart while busy
		'{'{MODE_TICK,  16'h0000, 16'hFFFF}, 1'b0, FROM_PREDICTOR},
		'{'{MODE_TICK,  16'h0000, 16'h0000}, 1'b0, FROM_PREDICTOR},
		'{'{MODE_TICK,  16'h0000, 16'h0000}, 1'b0, FROM_PREDICTOR},
		'{'{MODE_TICK,  16'h0000, 16'h0000}, 1'b0, FROM_PREDICTOR},
		'{'{MODE_TICK,  16'h0000, 16'h0000}, 1'b0, FROM_PREDICTOR},
		'{'{MODE_TICK,  16'h0000, 16'h0000}, 1'b0, FROM_PREDICTOR},
		'{'{MODE_TICK,  16'h0000, 16'h0000}, 1'b0, FROM_PREDICTOR},  // into off half
		'{'{MODE_START, 16'h0000, 16'hFFFF}, 1'b1, REST_HI},   // longest rest
		'{'{MODE_TICK,  16'h0000, 16'h0000}, 1'b1, REST_HI},
		'{'{MODE_START, 16'h0000, 16'h0000}, 1'b1, DONE_HI},   // rest dropped
		'{'{MODE_TICK,  16'hFFFF, 16'hFFFF}, 1'b1, IDLE_HI}
	};

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic res_valid;
	logic res_stall;
	res_t res;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_data;

	buzzer_tone_generator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// tone generator mirror
	logic               pin_active_low = 1'b1;
	logic [HALF_W-1:0]  half_ticks     = '0;
	logic [COUNT_W-1:0] periods_to_go  = '0;
	logic [HALF_W-1:0]  phase_left     = '0;
	logic               in_off         = 1'b0;
	logic [COUNT_W-1:0] rest_left      = '0;
	logic               gen_running    = 1'b0;
	logic               gen_resting    = 1'b0;

	res_t expected_res [$];
	bit   cmd_idle = 1'b1;
	bit   res_idle = 1'b1;
	int   cycle_count = 0;
	int   n_beats = 0;
	int   n_live = 0;
	int   n_results = 0;
	int   n_done = 0;
	int   n_full_runs = 0;
	int   n_cfg = 0;
	int   n_errors = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timed out after %0d cycles, %0d results still owed",
				cycle_count, expected_res.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic void gen_clear();
		gen_running   = 1'b0;
		gen_resting   = 1'b0;
		in_off        = 1'b0;
		phase_left    = '0;
		periods_to_go = '0;
		rest_left     = '0;
	endfunction

	// advances the mirror by one command beat and returns its result beat
	function automatic res_t tone_predict(input cmd_t c);
		logic [COUNT_W-1:0] total;
		logic [HALF_W-1:0]  hp;
		logic [COUNT_W-1:0] per;
		logic               done;
		logic               snd;
		res_t               r;
		done = 1'b0;
		if (c.mode == MODE_START) begin
			n_live++;
			total = COUNT_W'(32'(c.length_ms) * MS_TICKS);
			gen_clear();
			if (c.freq_hz == '0) begin
				if (total == '0) begin
					done = 1'b1;
				end else begin
					gen_running = 1'b1;
					gen_resting = 1'b1;
					rest_left   = total;
				end
			end else begin
				hp  = HALF_W'(TONE_NUM / int'(c.freq_hz));
				per = COUNT_W'(32'(total) / (32'd2 * 32'(hp)));
				half_ticks = hp;
				if (per == '0) begin
					done = 1'b1;
				end else begin
					gen_running   = 1'b1;
					periods_to_go = per;
					phase_left    = hp;
				end
			end
		end else if (gen_running) begin
			n_live++;
			if (gen_resting) begin
				rest_left = rest_left - 1'b1;
				if (rest_left == '0) begin
					gen_clear();
					done = 1'b1;
				end
			end else begin
				phase_left = phase_left - 1'b1;
				if (phase_left == '0) begin
					if (!in_off) begin
						in_off     = 1'b1;
						phase_left = half_ticks;
					end else begin
						periods_to_go = periods_to_go - 1'b1;
						if (periods_to_go == '0) begin
							gen_clear();
							done = 1'b1;
						end else begin
							in_off     = 1'b0;
							phase_left = half_ticks;
						end
					end
				end
			end
			if (done)
				n_full_runs++;
		end
		snd = gen_running && !gen_resting && !in_off;
		r.pin_level = snd ^ pin_active_low;
		r.sounding  = snd;
		r.busy_res  = gen_running;
		r.done_res  = done;
		return r;
	endfunction

	function automatic int draw_wait(input bit idle_on);
		return idle_on ? int'($urandom_range(0, 18)) : 0;
	endfunction

	function automatic cmd_t rand_tick();
		cmd_t c;
		c.mode      = MODE_TICK;
		c.freq_hz   = 16'($urandom);
		c.length_ms = 16'($urandom);
		return c;
	endfunction

	// one command beat; the expectation is queued in the step it is taken
	task automatic send_beat(input cmd_t c, input logic typed, input res_t want);
		int   gap;
		res_t predicted;
		gap = draw_wait(cmd_idle);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (!(cmd_valid && !cmd_stall));
		n_beats++;
		predicted = tone_predict(c);
		expected_res.push_back(typed ? want : predicted);
	endtask

	task automatic settle(input int tail);
		cmd_valid <= 1'b0;
		while (expected_res.size() != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_polarity(input logic v);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		pin_active_low = v;
		n_cfg++;
	endtask

	// a start with random content followed by a run of ticks, or stray ticks
	task automatic play_sequence();
		int   kind;
		int   n;
		int   i;
		cmd_t c;
		if ($urandom_range(0, 9) == 0)
			cmd_idle = !cmd_idle;
		if ($urandom_range(0, 9) == 0)
			res_idle = !res_idle;
		kind = $urandom_range(0, 99);
		c.mode      = MODE_START;
		c.freq_hz   = 16'($urandom_range(7630, 65535));   // half periods of 7..65
		c.length_ms = 16'($urandom_range(1, 65535));
		n = $urandom_range(0, 150);
		if (kind >= 50 && kind < 65) begin
			c.freq_hz   = 16'($urandom);
			c.length_ms = 16'($urandom);
			n = $urandom_range(0, 30);
		end else if (kind >= 65 && kind < 75) begin
			// too short for a single period
			c.freq_hz   = 16'($urandom_range(1, 10));
			c.length_ms = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(0, 49));
			n = $urandom_range(0, 3);
		end else if (kind >= 75 && kind < 88) begin
			c.freq_hz   = '0;
			c.length_ms = $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom);
			n = $urandom_range(0, 30);
		end
		if (kind < 88)
			send_beat(c, 1'b0, FROM_PREDICTOR);
		else
			n = $urandom_range(1, 4);
		for (i = 0; i < n; i++)
			send_beat(rand_tick(), 1'b0, FROM_PREDICTOR);
	endtask

	task automatic play_to_end(input cmd_t c);
		send_beat(c, 1'b0, FROM_PREDICTOR);
		while (gen_running)
			send_beat(rand_tick(), 1'b0, FROM_PREDICTOR);
	endtask

	initial begin : result_side
		int   n;
		res_t want;
		res_t got;
		res_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			n = draw_wait(res_idle);
			if (n > 0) begin
				res_stall <= 1'b1;
				repeat (n) @(posedge clk);
				res_stall <= 1'b0;
			end
			do @(posedge clk); while (!(res_valid && !res_stall));
			got = res;
			n_results++;
			if (got.done_res === 1'b1)
				n_done++;
			if (expected_res.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("result beat %0d arrived with nothing expected: %b",
						n_results, got);
			end else begin
				want = expected_res.pop_front();
				if (got.pin_level !== want.pin_level || got.sounding !== want.sounding ||
						got.busy_res !== want.busy_res || got.done_res !== want.done_res) begin
					n_errors++;
					if (n_errors <= 10)
						$display({"result beat %0d: want pin=%b snd=%b busy=%b done=%b, ",
							"got pin=%b snd=%b busy=%b done=%b"}, n_results,
							want.pin_level, want.sounding, want.busy_res, want.done_res,
							got.pin_level, got.sounding, got.busy_res, got.done_res);
				end
			end
		end
	end

	initial begin : stimulus
		int   i;
		cmd_t c;
		arst_n    <= 1'b0;
		cmd_valid <= 1'b0;
		cmd       <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i])
			send_beat(DIRECTED[i].beat, DIRECTED[i].typed, DIRECTED[i].want);
		settle(4);

		write_polarity(1'b0);
		n_live = 0;
		while (n_live < RANDOM_LIVE)
			play_sequence();
		settle(4);

		write_polarity(1'b1);
		n_live = 0;
		while (n_live < RANDOM_LIVE)
			play_sequence();
		settle(4);

		// a one millisecond tone of a single period, played to its end
		write_polarity(1'b0);
		c.mode      = MODE_START;
		c.freq_hz   = 16'($urandom_range(1900, 1992));
		c.length_ms = 16'd1;
		play_to_end(c);
		settle(4);

		write_polarity(1'b1);
		for (i = 0; i < 2; i++)
			play_sequence();
		settle(60);

		$display("ran %0d command beats and checked %0d result beats, %0d of them done",
			n_beats, n_results, n_done);
		$display("%0d tones or rests ran out on a tick, %0d polarity writes, %0d errors",
			n_full_runs, n_cfg, n_errors);
		if (n_errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
